[design/bep_pkg.sv]
// ----------------------------------------------------------------------------
// bep_pkg
// Shared types, constants and tables for the back-EMF angle PLL: control word
// layout of the microcode, configuration register set and quarter-wave sine.
// ----------------------------------------------------------------------------
package bep_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_BITS         = IDX_BITS - 2;
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;

  localparam int POLY_A = 51472;
  localparam int POLY_B = 21024;
  localparam int POLY_C = 2320;

  localparam int PROD_W = 50;
  localparam int ACC_W  = 52;

  localparam int STEP_BITS = 4;

  // Register indexes
  localparam logic [2:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN      = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEP_GAIN = 3'd2;
  localparam logic [2:0] REG_FILTER_WEIGHT   = 3'd3;
  localparam logic [2:0] REG_SPEED_SCALE     = 3'd4;

  localparam logic [15:0] RST_PROP_GAIN       = 16'd5120;
  localparam logic [15:0] RST_INTEG_GAIN      = 16'd512;
  localparam logic [15:0] RST_ANGLE_STEP_GAIN = 16'd267;
  localparam logic [15:0] RST_FILTER_WEIGHT   = 16'd326;
  localparam logic [15:0] RST_SPEED_SCALE     = 16'd489;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] angle_step_gain;
    logic [15:0] filter_weight;
    logic [15:0] speed_scale;
  } cfg_regs_t;

  typedef enum logic [2:0] {A_COS, A_SIN, A_ERR, A_FREQ, A_DIFF, A_SPDF} a_sel_t;
  typedef enum logic [2:0] {B_EA, B_EB, B_KI, B_KP, B_KA, B_KW, B_KS} b_sel_t;
  typedef enum logic [2:0] {BASE_ZERO, BASE_ACC, BASE_INTEG, BASE_FREQ, BASE_SPDF} base_t;
  typedef enum logic {TERM_PROD, TERM_SPDF} term_t;
  typedef enum logic [1:0] {PSH_0, PSH_8, PSH_16} pshift_t;
  typedef enum logic [2:0] {
    DST_NONE, DST_ERR, DST_INTEG, DST_FREQ, DST_DIFF, DST_ANGLE, DST_SPDF, DST_SPEED
  } dst_t;
  typedef enum logic [1:0] {COND_NONE, COND_IN, COND_OUT} cond_t;

  typedef struct packed {
    logic    trig_en;
    logic    mul_en;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    acc_en;
    base_t   base;
    term_t   term;
    logic    term_neg;
    pshift_t pshift;
    dst_t    dst;
    logic    out_en;
    cond_t   cond;
    logic    last;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    trig_en:  1'b0,
    mul_en:   1'b0,
    a_sel:    A_COS,
    b_sel:    B_EA,
    acc_en:   1'b0,
    base:     BASE_ZERO,
    term:     TERM_PROD,
    term_neg: 1'b0,
    pshift:   PSH_0,
    dst:      DST_NONE,
    out_en:   1'b0,
    cond:     COND_NONE,
    last:     1'b0
  };

  typedef logic [15:0] qtr_tbl_t [QTR_DEPTH];

  // First quadrant of the sine, Q1.15, evaluated at elaboration
  function automatic qtr_tbl_t build_qtr();
    qtr_tbl_t tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      x  = (longint'(k) * 131072) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 15;
      t  = (longint'(POLY_C) * x2) >> 15;
      t  = ((longint'(POLY_B) - t) * x2) >> 15;
      t  = longint'(POLY_A) - t;
      t  = (t * x) >> 15;
      tbl[k] = (t > 32767) ? 16'd32767 : 16'(t);
    end
    return tbl;
  endfunction

  localparam qtr_tbl_t QTR_TABLE = build_qtr();

endpackage

[design/bep_sine_lookup.sv]
// ----------------------------------------------------------------------------
// bep_sine_lookup
// Folds a table index into quadrant and offset and returns sine and cosine
// from the quarter-wave table.
// ----------------------------------------------------------------------------
module bep_sine_lookup (
  input  logic [bep_pkg::IDX_BITS-1:0] idx,
  output logic signed [15:0]           sin_v,
  output logic signed [15:0]           cos_v
);
  import bep_pkg::*;

  logic [1:0]          quad;
  logic [1:0]          quad_c;
  logic [QTR_BITS:0]   off;
  logic [QTR_BITS:0]   off_mir;
  logic [15:0]         mag_s;
  logic [15:0]         mag_c;

  function automatic logic [15:0] qtr_mag(input logic [QTR_BITS:0] k);
    if (k == (QTR_BITS + 1)'(QTR_DEPTH)) begin
      return 16'd32767;
    end
    return QTR_TABLE[k[QTR_BITS-1:0]];
  endfunction

  always_comb begin
    quad    = idx[IDX_BITS-1 -: 2];
    quad_c  = quad + 2'd1;
    off     = {1'b0, idx[QTR_BITS-1:0]};
    off_mir = (QTR_BITS + 1)'(QTR_DEPTH) - off;
    mag_s   = qtr_mag(quad[0] ? off_mir : off);
    mag_c   = qtr_mag(quad_c[0] ? off_mir : off);
    sin_v   = quad[1] ? -$signed(mag_s) : $signed(mag_s);
    cos_v   = quad_c[1] ? -$signed(mag_c) : $signed(mag_c);
  end

endmodule

[design/bep_ucode_rom.sv]
// ----------------------------------------------------------------------------
// bep_ucode_rom
// Program store: one control word per step of the PLL update.
// ----------------------------------------------------------------------------
module bep_ucode_rom (
  input  logic [bep_pkg::STEP_BITS-1:0] step,
  output bep_pkg::ctrl_word_t           cw
);
  import bep_pkg::*;

  always_comb begin
    cw = CW_NOP;
    case (step)
      4'd0: begin
        cw.cond = COND_IN;
      end
      4'd1: begin
        cw.trig_en = 1'b1;
      end
      4'd2: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_COS;
        cw.b_sel  = B_EA;
      end
      4'd3: begin
        cw.mul_en   = 1'b1;
        cw.a_sel    = A_SIN;
        cw.b_sel    = B_EB;
        cw.acc_en   = 1'b1;
        cw.base     = BASE_ZERO;
        cw.term_neg = 1'b1;
      end
      4'd4: begin
        cw.base     = BASE_ACC;
        cw.term_neg = 1'b1;
        cw.dst      = DST_ERR;
      end
      4'd5: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_ERR;
        cw.b_sel  = B_KI;
      end
      4'd6: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_ERR;
        cw.b_sel  = B_KP;
        cw.base   = BASE_INTEG;
        cw.pshift = PSH_8;
        cw.dst    = DST_INTEG;
      end
      4'd7: begin
        cw.base   = BASE_INTEG;
        cw.pshift = PSH_8;
        cw.dst    = DST_FREQ;
      end
      4'd8: begin
        cw.mul_en   = 1'b1;
        cw.a_sel    = A_FREQ;
        cw.b_sel    = B_KA;
        cw.base     = BASE_FREQ;
        cw.term     = TERM_SPDF;
        cw.term_neg = 1'b1;
        cw.dst      = DST_DIFF;
      end
      4'd9: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_DIFF;
        cw.b_sel  = B_KW;
        cw.base   = BASE_ZERO;
        cw.pshift = PSH_8;
        cw.dst    = DST_ANGLE;
      end
      4'd10: begin
        cw.base   = BASE_SPDF;
        cw.pshift = PSH_16;
        cw.dst    = DST_SPDF;
      end
      4'd11: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_SPDF;
        cw.b_sel  = B_KS;
      end
      4'd12: begin
        cw.base   = BASE_ZERO;
        cw.pshift = PSH_8;
        cw.dst    = DST_SPEED;
      end
      4'd13: begin
        cw.out_en = 1'b1;
        cw.cond   = COND_OUT;
        cw.last   = 1'b1;
      end
      default: begin
        cw.last = 1'b1;
      end
    endcase
  end

endmodule

[design/bep_datapath.sv]
// ----------------------------------------------------------------------------
// bep_datapath
// Shared multiplier, shift/add unit with saturation, and the working
// registers of the PLL, steered by the control word.
// ----------------------------------------------------------------------------
module bep_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  bep_pkg::ctrl_word_t              cw,
  input  bep_pkg::cfg_regs_t               cfg,
  input  logic                             capture,
  input  logic signed [15:0]               emf_alpha,
  input  logic signed [15:0]               emf_beta,
  input  logic [15:0]                      angle_in,
  output logic [bep_pkg::ANGLE_BITS-1:0]   angle_res,
  output logic signed [31:0]               freq,
  output logic signed [15:0]               speed_res
);
  import bep_pkg::*;

  localparam logic signed [ACC_W-1:0] P32 = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] N32 = -P32 - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] P16 = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] N16 = ACC_W'(-32768);

  logic signed [15:0]       ea;
  logic signed [15:0]       eb;
  logic [ANGLE_BITS-1:0]    ang;
  logic signed [15:0]       sin_v;
  logic signed [15:0]       cos_v;
  logic signed [15:0]       sin_l;
  logic signed [15:0]       cos_l;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [17:0]       err;
  logic signed [31:0]       integ;
  logic signed [32:0]       diff;
  logic signed [31:0]       spdf;
  logic signed [32:0]       a_op;
  logic signed [16:0]       b_op;
  logic signed [ACC_W-1:0]  sp;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  basev;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > P32) begin
      return 32'sh7FFF_FFFF;
    end else if (v < N32) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > P16) begin
      return 16'sh7FFF;
    end else if (v < N16) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  bep_sine_lookup u_sine (
    .idx   (ang[ANGLE_BITS-1 -: IDX_BITS]),
    .sin_v (sin_l),
    .cos_v (cos_l)
  );

  always_comb begin
    case (cw.a_sel)
      A_COS:   a_op = 33'(cos_v);
      A_SIN:   a_op = 33'(sin_v);
      A_ERR:   a_op = 33'(err);
      A_FREQ:  a_op = 33'(freq);
      A_DIFF:  a_op = diff;
      A_SPDF:  a_op = 33'(spdf);
      default: a_op = '0;
    endcase
    case (cw.b_sel)
      B_EA:    b_op = 17'(ea);
      B_EB:    b_op = 17'(eb);
      B_KI:    b_op = $signed({1'b0, cfg.integ_gain});
      B_KP:    b_op = $signed({1'b0, cfg.prop_gain});
      B_KA:    b_op = $signed({1'b0, cfg.angle_step_gain});
      B_KW:    b_op = $signed({1'b0, cfg.filter_weight});
      B_KS:    b_op = $signed({1'b0, cfg.speed_scale});
      default: b_op = '0;
    endcase
    prod_next = a_op * b_op;

    case (cw.pshift)
      PSH_8:   sp = ACC_W'(prod >>> 8);
      PSH_16:  sp = ACC_W'(prod >>> 16);
      default: sp = ACC_W'(prod);
    endcase
    case (cw.term)
      TERM_SPDF: term = ACC_W'(spdf);
      default:   term = sp;
    endcase
    case (cw.base)
      BASE_ACC:   basev = acc;
      BASE_INTEG: basev = ACC_W'(integ);
      BASE_FREQ:  basev = ACC_W'(freq);
      BASE_SPDF:  basev = ACC_W'(spdf);
      default:    basev = '0;
    endcase
    acc_next = cw.term_neg ? (basev - term) : (basev + term);
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      spdf  <= '0;
    end else begin
      case (cw.dst)
        DST_INTEG: integ <= sat32(acc_next);
        DST_SPDF:  spdf  <= sat32(acc_next);
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (capture) begin
      ea  <= emf_alpha;
      eb  <= emf_beta;
      ang <= angle_in[ANGLE_BITS-1:0];
    end
    if (cw.trig_en) begin
      sin_v <= sin_l;
      cos_v <= cos_l;
    end
    if (cw.mul_en) begin
      prod <= prod_next;
    end
    if (cw.acc_en) begin
      acc <= acc_next;
    end
    case (cw.dst)
      DST_ERR:   err       <= acc_next[32:15];
      DST_FREQ:  freq      <= sat32(acc_next);
      DST_DIFF:  diff      <= acc_next[32:0];
      DST_ANGLE: angle_res <= ang + acc_next[ANGLE_BITS-1:0];
      DST_SPEED: speed_res <= sat16(acc_next);
      default: begin
      end
    endcase
  end

endmodule

[design/back_emf_angle_pll_top.sv]
// ----------------------------------------------------------------------------
// back_emf_angle_pll_top
// Back-EMF phase-locked loop: angle and speed estimator run by a microcoded
// sequencer over a single shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: a request is captured at the first of the 14 program steps, which
// run each update through the one shared 33x17 multiplier; no new request is taken
// until the result is registered onto the outputs at the last step.
// Reset: registers to their defaults, integrator and speed filter cleared,
// sequencer at its first step with no result pending.
// ----------------------------------------------------------------------------
module back_emf_angle_pll_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] emf_alpha,
  input  logic signed [15:0] emf_beta,
  input  logic [15:0]        angle_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        angle_out,
  output logic signed [31:0] freq_est,
  output logic signed [15:0] speed_est
);
  import bep_pkg::*;

  logic [STEP_BITS-1:0]  step;
  logic [STEP_BITS-1:0]  step_next;
  ctrl_word_t            cw;
  cfg_regs_t             cfg;
  logic                  stall;
  logic                  out_load;
  logic                  capture;
  logic [ANGLE_BITS-1:0] angle_res;
  logic signed [31:0]    freq;
  logic signed [15:0]    speed_res;

  bep_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  bep_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .cfg       (cfg),
    .capture   (capture),
    .emf_alpha (emf_alpha),
    .emf_beta  (emf_beta),
    .angle_in  (angle_in),
    .angle_res (angle_res),
    .freq      (freq),
    .speed_res (speed_res)
  );

  always_comb begin
    in_ready = (cw.cond == COND_IN);
    capture  = in_valid && in_ready;
    stall    = ((cw.cond == COND_IN) && !in_valid) ||
               ((cw.cond == COND_OUT) && out_valid && !out_ready);
    out_load = cw.out_en && !stall;
    if (stall) begin
      step_next = step;
    end else if (cw.last) begin
      step_next = '0;
    end else begin
      step_next = step + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step                <= '0;
      out_valid           <= 1'b0;
      cfg.prop_gain       <= RST_PROP_GAIN;
      cfg.integ_gain      <= RST_INTEG_GAIN;
      cfg.angle_step_gain <= RST_ANGLE_STEP_GAIN;
      cfg.filter_weight   <= RST_FILTER_WEIGHT;
      cfg.speed_scale     <= RST_SPEED_SCALE;
    end else begin
      step <= step_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:       cfg.prop_gain       <= cfg_data;
          REG_INTEG_GAIN:      cfg.integ_gain      <= cfg_data;
          REG_ANGLE_STEP_GAIN: cfg.angle_step_gain <= cfg_data;
          REG_FILTER_WEIGHT:   cfg.filter_weight   <= cfg_data;
          REG_SPEED_SCALE:     cfg.speed_scale     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      angle_out <= 16'(angle_res);
      freq_est  <= freq;
      speed_est <= speed_res;
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the back-EMF angle PLL against a cycle-free model of its arithmetic.
// Requests are queued per phase, gains are rewritten between phases while the
// loop is idle, and each estimate is compared field by field in request order.
// ----------------------------------------------------------------------------
module tb;
  import bep_pkg::*;

  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam int    HOLD_CYCLES = 400;
  localparam longint ACC_MAX    = 64'sd2147483647;
  localparam longint ACC_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        angle;
  } emf_request_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [31:0] freq;
    logic [15:0] speed;
  } estimate_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] emf_alpha = '0;
  logic signed [15:0] emf_beta = '0;
  logic [15:0]        angle_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        angle_out;
  logic signed [31:0] freq_est;
  logic signed [15:0] speed_est;

  emf_request_t emf_requests[$];
  estimate_t    expected_estimates[$];
  emf_request_t req;
  estimate_t    want;

  cfg_regs_t pll_cfg;
  longint    integ_acc;
  longint    speed_acc;

  int   n_requests_queued = 0;
  int   n_estimates_checked = 0;
  int   n_mismatch = 0;
  int   n_cycles = 0;
  int   tx_gap = 0;
  int   rx_stall = 0;
  int   hold_left = 0;
  logic in_taken = 1'b0;
  logic tx_idle_en = 1'b0;
  logic rx_idle_en = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  back_emf_angle_pll_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .emf_alpha (emf_alpha),
    .emf_beta  (emf_beta),
    .angle_in  (angle_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_out (angle_out),
    .freq_est  (freq_est),
    .speed_est (speed_est)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // Quarter-wave polynomial sine, Q1.15
  function automatic longint sine_q15(longint idx);
    longint x;
    longint x2;
    longint t;
    longint quad;
    quad = idx / QTR_DEPTH;
    x = ((idx % QTR_DEPTH) * 32768) / QTR_DEPTH;
    if (quad[0]) x = 32768 - x;
    x2 = (x * x) >> 15;
    t = (POLY_C * x2) >> 15;
    t = ((POLY_B - t) * x2) >> 15;
    t = POLY_A - t;
    t = (t * x) >> 15;
    if (t > 32767) t = 32767;
    return quad[1] ? -t : t;
  endfunction

  function automatic estimate_t advance_pll(emf_request_t r);
    longint    idx;
    longint    s;
    longint    c;
    longint    err;
    longint    freq;
    longint    delta;
    longint    spd;
    estimate_t e;
    idx = longint'(r.angle) >> (ANGLE_BITS - IDX_BITS);
    s = sine_q15(idx);
    c = sine_q15((idx + QTR_DEPTH) % SINE_TABLE_DEPTH);
    err = (-longint'(r.alpha) * c - longint'(r.beta) * s) >>> 15;
    integ_acc = clamp32(integ_acc + ((err * longint'(pll_cfg.integ_gain)) >>> 8));
    freq = clamp32(((err * longint'(pll_cfg.prop_gain)) >>> 8) + integ_acc);
    delta = (freq * longint'(pll_cfg.angle_step_gain)) >>> 8;
    speed_acc = clamp32(speed_acc
                        + (((freq - speed_acc) * longint'(pll_cfg.filter_weight)) >>> 16));
    spd = (speed_acc * longint'(pll_cfg.speed_scale)) >>> 8;
    if (spd > 32767) spd = 32767;
    else if (spd < -32768) spd = -32768;
    e.angle = 16'(longint'(r.angle) + delta);
    e.freq  = 32'(freq);
    e.speed = 16'(spd);
    return e;
  endfunction

  // Sampling, prediction and checking
  always @(posedge clk) begin
    in_taken = 1'b0;
    n_cycles++;
    if (rst) begin
      pll_cfg = '{RST_PROP_GAIN, RST_INTEG_GAIN, RST_ANGLE_STEP_GAIN,
                  RST_FILTER_WEIGHT, RST_SPEED_SCALE};
      integ_acc = 0;
      speed_acc = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:       pll_cfg.prop_gain = cfg_data;
          REG_INTEG_GAIN:      pll_cfg.integ_gain = cfg_data;
          REG_ANGLE_STEP_GAIN: pll_cfg.angle_step_gain = cfg_data;
          REG_FILTER_WEIGHT:   pll_cfg.filter_weight = cfg_data;
          REG_SPEED_SCALE:     pll_cfg.speed_scale = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_estimates.push_back(advance_pll('{emf_alpha, emf_beta, angle_in}));
      end
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected estimate: angle %0d freq %0d speed %0d",
                     angle_out, freq_est, speed_est);
        end else begin
          want = expected_estimates.pop_front();
          n_estimates_checked++;
          if (angle_out !== want.angle || freq_est !== want.freq ||
              speed_est !== want.speed) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("estimate %0d: angle %0d exp %0d, freq %0d exp %0d, speed %0d exp %0d",
                       n_estimates_checked, angle_out, want.angle, freq_est,
                       $signed(want.freq), speed_est, $signed(want.speed));
          end
        end
      end
    end
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (emf_requests.size() > 0) begin
        req = emf_requests.pop_front();
        emf_alpha <= req.alpha;
        emf_beta  <= req.beta;
        angle_in  <= req.angle;
        in_valid  <= 1'b1;
        if (tx_idle_en && $urandom_range(0, 3) == 0) tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result acceptance, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 5) == 0) rx_stall = pick_gap();
    end
  end

  task automatic queue_request(logic [15:0] a, logic [15:0] b, logic [15:0] ang);
    emf_requests.push_back('{a, b, ang});
    n_requests_queued++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] ka,
                           logic [15:0] kw, logic [15:0] ks);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_ANGLE_STEP_GAIN, ka);
    write_reg(REG_FILTER_WEIGHT, kw);
    write_reg(REG_SPEED_SCALE, ks);
  endtask

  task automatic wait_drained();
    while (n_estimates_checked < n_requests_queued) @(negedge clk);
  endtask

  // Mostly steady EMF vectors with a turning angle, some pure noise
  task automatic queue_random(int count);
    logic [15:0] a0;
    logic [15:0] b0;
    logic [15:0] ang;
    logic [15:0] step;
    logic        noisy;
    int          len;
    while (count > 0) begin
      len   = $urandom_range(4, 40);
      a0    = 16'($urandom);
      b0    = 16'($urandom);
      ang   = 16'($urandom);
      step  = 16'($urandom_range(0, 1023) - 512);
      noisy = ($urandom_range(0, 9) < 3);
      if ($urandom_range(0, 3) == 0) begin
        a0 = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        b0 = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
      for (int k = 0; k < len && count > 0; k++) begin
        if (noisy) queue_request(16'($urandom), 16'($urandom), 16'($urandom));
        else queue_request(16'(a0 + $urandom_range(0, 63) - 32),
                           16'(b0 + $urandom_range(0, 63) - 32), ang);
        ang   = ang + step;
        count = count - 1;
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 9; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
          2: set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
          3: set_gains(16'd256, 16'd1, 16'd267, 16'hffff, 16'hffff);
          4: begin
            set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            // writes past the last register must be dropped
            for (int i = int'(REG_SPEED_SCALE) + 1; i < 8; i++)
              write_reg(3'(i), 16'($urandom));
          end
          5: set_gains(16'd0, 16'hffff, 16'hffff, 16'd1, 16'd256);
          6: set_gains(RST_PROP_GAIN, RST_INTEG_GAIN, RST_ANGLE_STEP_GAIN,
                       RST_FILTER_WEIGHT, RST_SPEED_SCALE);
          7: set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
          default: set_gains(16'($urandom_range(0, 8192)), 16'($urandom_range(0, 1024)),
                             16'($urandom_range(0, 2048)), 16'($urandom_range(0, 4096)),
                             16'($urandom_range(0, 1024)));
        endcase
        cfg_we <= 1'b0;
      end
      tx_idle_en = (phase != 4) && ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        queue_request(16'h0000, 16'h0000, 16'h0000);
        queue_request(16'h7fff, 16'h7fff, 16'h0000);
        queue_request(16'h8000, 16'h8000, 16'h0000);
        queue_request(16'h8000, 16'h7fff, 16'h4000);
        queue_request(16'h7fff, 16'h8000, 16'h8000);
        queue_request(16'h8000, 16'h8000, 16'hc000);
        queue_request(16'hffff, 16'hffff, 16'hffff);
        queue_request(16'h7fff, 16'h0000, 16'h3fff);
        queue_request(16'h0000, 16'h7fff, 16'h003f);
        queue_request(16'h0001, 16'hffff, 16'h0040);
        queue_request(16'h8000, 16'h0000, 16'h4040);
        queue_request(16'h0000, 16'h8000, 16'h7fc0);
        queue_request(16'h7fff, 16'h7fff, 16'h8040);
        queue_request(16'h8000, 16'h7fff, 16'hbfff);
        queue_request(16'h3039, 16'ha460, 16'hc000);
        queue_request(16'h8000, 16'h8000, 16'hffc0);
        queue_request(16'haaaa, 16'h5555, 16'ha5a5);
        queue_request(16'h5555, 16'haaaa, 16'h5a5a);
        for (int i = 0; i < 6; i++) queue_request(16'h8000, 16'h8000, 16'h2000);
      end else begin
        queue_random(200);
        if (phase == 4) hold_go = 1'b1;
      end
    end
    wait_drained();
    repeat (20) @(negedge clk);
    if (n_mismatch == 0 && expected_estimates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
